@@ hw/rtl/mbrtu_pkg.sv @@
// Package: codes, result word layout and the CRC-16 byte update for the Modbus RTU master.
`default_nettype none

package mbrtu_pkg;

  localparam int CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CFG_MAX_QUANTITY = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_REG_CAPACITY = 1'b1;

  localparam logic CMD_SEND = 1'b0;
  localparam logic CMD_RX   = 1'b1;

  localparam logic [1:0] KIND_TX     = 2'd0;
  localparam logic [1:0] KIND_WORD   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_REJECTED = 3'd1;
  localparam logic [2:0] ST_SLAVE    = 3'd2;
  localparam logic [2:0] ST_FUNCTION = 3'd3;
  localparam logic [2:0] ST_COUNT    = 3'd4;
  localparam logic [2:0] ST_SHORT    = 3'd5;
  localparam logic [2:0] ST_CAPACITY = 3'd6;
  localparam logic [2:0] ST_CRC      = 3'd7;

  localparam logic [7:0]  FUNC_READ_HOLDING = 8'd3;
  localparam logic [7:0]  MAX_SLAVE         = 8'd247;
  localparam logic [7:0]  MAX_BYTE_COUNT    = 8'd250;
  localparam logic [7:0]  HEADER_BYTES      = 8'd3;
  localparam logic [7:0]  FRAME_OVERHEAD    = 8'd5;  // header plus CRC
  localparam logic [15:0] CRC_INIT          = 16'hFFFF;
  localparam logic [15:0] CRC_POLY          = 16'hA001;
  localparam logic [2:0]  REQ_LAST_BYTE     = 3'd7;
  localparam logic [2:0]  REQ_CRC_LO        = 3'd6;

  localparam int OutDataW = 48;
  localparam int InDataW  = 48;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  tx_byte;
    logic [15:0] reg_value;
    logic [6:0]  reg_index;
    logic [2:0]  status;
    logic [6:0]  word_total;
    logic        last;
  } result_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic result_t status_result(input logic [2:0] st, input logic [6:0] cnt);
    result_t r;
    r = '0;
    r.kind = KIND_STATUS;
    r.status = st;
    r.word_total = cnt;
    r.last = 1'b1;
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/modbus_rtu_read_holding_master_unit.sv @@
// Top level: Modbus RTU read-holding-registers master, request builder and response parser.
//
//  channel | direction | handshake             | payload
//  s_*     | in        | s_tvalid / s_tready   | s_tuser cmd, s_tdata operands/byte, s_tlast
//  m_*     | out       | m_tvalid / m_tready   | m_tuser kind, m_tdata fields, m_tlast
//  cfg_*   | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// A response byte is parsed in the cycle it is accepted; it yields up to two words
// (register word, status), drained one per cycle from two holding registers. A send
// command yields eight words, one per cycle; the request CRC is built one byte per cycle
// as the bytes leave. Input is taken again in the cycle the final pending word is taken,
// so single-word items run at one per cycle. Rates hold only while m_tready is high.
// rst (synchronous) clears the parser and drops pending words; cfg_ready is always high.
`default_nettype none

module modbus_rtu_read_holding_master_unit
  import mbrtu_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  // [7:0] target_id, [23:8] start_addr, [39:24] quantity, [47:40] rx_byte
  input  wire logic [InDataW-1:0]   s_tdata,
  // [0] cmd
  input  wire logic                 s_tuser,
  input  wire logic                 s_tlast,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  // [7:0] tx_byte, [23:8] reg_value, [30:24] reg_index, [33:31] status,
  // [40:34] word_total, [47:41] zero
  output logic [OutDataW-1:0]       m_tdata,
  // [1:0] kind
  output logic [1:0]                m_tuser,
  output logic                      m_tlast,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CfgIdxW-1:0]   cfg_index,
  input  wire logic [7:0]           cfg_data
);

  // configuration
  logic [6:0] max_quantity;
  logic [7:0] reg_capacity;

  // parser state
  logic [7:0]  last_slave;
  logic [7:0]  byte_position;
  logic [7:0]  expected_bytes;
  logic [15:0] crc_accum;
  logic [7:0]  held_byte;
  logic [2:0]  pending_error;
  logic        frame_done;

  // output side
  logic [3:0]  rem;
  logic        send_job;
  logic [2:0]  tx_idx;
  logic [15:0] tx_crc;
  logic [7:0]  req_sid;
  logic [15:0] req_addr;
  logic [15:0] req_qty;
  result_t     head;
  result_t     tail;

  logic in_take, out_take;

  // input fields
  logic        cmd;
  logic [7:0]  sid, b;
  logic [15:0] addr, qty;
  logic        lastflag;

  assign cmd      = s_tuser;
  assign sid      = s_tdata[7:0];
  assign addr     = s_tdata[23:8];
  assign qty      = s_tdata[39:24];
  assign b        = s_tdata[47:40];
  assign lastflag = s_tlast;

  assign cfg_ready = 1'b1;
  assign m_tvalid  = (rem != 4'd0);
  assign s_tready  = (rem == 4'd0) || ((rem == 4'd1) && m_tready);
  assign in_take   = s_tvalid && s_tready;
  assign out_take  = m_tvalid && m_tready;

  // request check
  logic [16:0] addr_end;
  logic        req_ok;
  assign addr_end = {1'b0, addr} + {1'b0, qty};
  assign req_ok = (sid != 8'd0) && (sid <= MAX_SLAVE) && (qty != 16'd0)
               && (qty <= {9'd0, max_quantity}) && (addr_end <= 17'h10000);

  // response byte parse
  logic [7:0]  data_bytes;
  logic        in_data;
  logic        at_crc_lo;
  logic [7:0]  data_off;
  logic [2:0]  st;
  logic        st_valid;
  logic [6:0]  cnt;
  logic        word_valid;
  result_t     word_res;
  logic [7:0]  byte_position_next;
  logic [7:0]  expected_bytes_next;
  logic [15:0] crc_accum_next;
  logic [7:0]  held_byte_next;
  logic [2:0]  pending_error_next;
  logic        frame_done_next;

  assign data_bytes = expected_bytes - FRAME_OVERHEAD;
  assign in_data    = (expected_bytes < FRAME_OVERHEAD)
                   || (byte_position < expected_bytes - 8'd2);
  assign at_crc_lo  = (byte_position == expected_bytes - 8'd2);
  assign data_off   = byte_position - HEADER_BYTES;

  always_comb begin
    byte_position_next  = byte_position;
    expected_bytes_next = expected_bytes;
    crc_accum_next      = crc_accum;
    held_byte_next      = held_byte;
    pending_error_next  = pending_error;
    frame_done_next     = frame_done;
    st         = ST_OK;
    st_valid   = 1'b0;
    cnt        = 7'd0;
    word_valid = 1'b0;
    word_res   = '0;
    word_res.kind      = KIND_WORD;
    word_res.reg_value = {held_byte, b};
    word_res.reg_index = data_off[7:1];

    if (!frame_done) begin
      if (byte_position < HEADER_BYTES) begin
        crc_accum_next = crc_byte(crc_accum, b);
        if (byte_position == 8'd0) begin
          if (b != last_slave) begin
            st = ST_SLAVE;
            st_valid = 1'b1;
          end
        end else if (byte_position == 8'd1) begin
          if (b != FUNC_READ_HOLDING) begin
            st = ST_FUNCTION;
            st_valid = 1'b1;
          end
        end else begin
          if ((b == 8'd0) || b[0] || (b > MAX_BYTE_COUNT)) begin
            st = ST_COUNT;
            st_valid = 1'b1;
          end else begin
            expected_bytes_next = b + FRAME_OVERHEAD;
            if ({1'b0, b[7:1]} > reg_capacity) begin
              pending_error_next = ST_CAPACITY;
            end
          end
        end
      end else if (in_data) begin
        crc_accum_next = crc_byte(crc_accum, b);
        if (!data_off[0]) begin
          held_byte_next = b;
        end else if (pending_error == ST_OK) begin
          word_valid = 1'b1;
        end
      end else if (at_crc_lo) begin
        held_byte_next = b;
      end else begin
        st_valid = 1'b1;
        if (pending_error != ST_OK) begin
          st = pending_error;
        end else if ({b, held_byte} == crc_accum) begin
          st  = ST_OK;
          cnt = data_bytes[7:1];
        end else begin
          st = ST_CRC;
        end
      end
      byte_position_next = byte_position + 8'd1;
      if (!st_valid && lastflag) begin
        st = ST_SHORT;
        st_valid = 1'b1;
      end
      if (st_valid) begin
        frame_done_next = 1'b1;
      end
    end

    // the byte carrying the last flag always restarts the parser
    if (lastflag) begin
      byte_position_next  = 8'd0;
      expected_bytes_next = 8'd0;
      crc_accum_next      = CRC_INIT;
      held_byte_next      = 8'd0;
      pending_error_next  = ST_OK;
      frame_done_next     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_quantity <= 7'd125;
      reg_capacity <= 8'd125;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MAX_QUANTITY: max_quantity <= cfg_data[6:0];
        CFG_REG_CAPACITY: reg_capacity <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_slave     <= 8'd0;
      byte_position  <= 8'd0;
      expected_bytes <= 8'd0;
      crc_accum      <= CRC_INIT;
      held_byte      <= 8'd0;
      pending_error  <= ST_OK;
      frame_done     <= 1'b0;
    end else if (in_take) begin
      if (cmd == CMD_SEND) begin
        byte_position  <= 8'd0;
        expected_bytes <= 8'd0;
        crc_accum      <= CRC_INIT;
        held_byte      <= 8'd0;
        pending_error  <= ST_OK;
        frame_done     <= 1'b0;
        if (req_ok) begin
          last_slave <= sid;
        end
      end else begin
        byte_position  <= byte_position_next;
        expected_bytes <= expected_bytes_next;
        crc_accum      <= crc_accum_next;
        held_byte      <= held_byte_next;
        pending_error  <= pending_error_next;
        frame_done     <= frame_done_next;
      end
    end
  end

  // request byte on the wire at tx_idx
  logic [7:0] tx_cur;
  always_comb begin
    unique case (tx_idx)
      3'd0:    tx_cur = req_sid;
      3'd1:    tx_cur = FUNC_READ_HOLDING;
      3'd2:    tx_cur = req_addr[15:8];
      3'd3:    tx_cur = req_addr[7:0];
      3'd4:    tx_cur = req_qty[15:8];
      3'd5:    tx_cur = req_qty[7:0];
      3'd6:    tx_cur = tx_crc[7:0];
      default: tx_cur = tx_crc[15:8];
    endcase
  end

  result_t cur;
  always_comb begin
    if (send_job) begin
      cur = '0;
      cur.kind    = KIND_TX;
      cur.tx_byte = tx_cur;
      cur.last    = (tx_idx == REQ_LAST_BYTE);
    end else begin
      cur = head;
    end
  end

  assign m_tuser = cur.kind;
  assign m_tlast = cur.last;
  assign m_tdata = {7'd0, cur.word_total, cur.status, cur.reg_index, cur.reg_value, cur.tx_byte};

  always_ff @(posedge clk) begin
    if (rst) begin
      rem      <= 4'd0;
      send_job <= 1'b0;
      tx_idx   <= 3'd0;
    end else if (in_take) begin
      if (cmd == CMD_SEND) begin
        if (req_ok) begin
          rem      <= 4'd8;
          send_job <= 1'b1;
          tx_idx   <= 3'd0;
          tx_crc   <= CRC_INIT;
          req_sid  <= sid;
          req_addr <= addr;
          req_qty  <= qty;
        end else begin
          rem      <= 4'd1;
          send_job <= 1'b0;
          head     <= status_result(ST_REJECTED, 7'd0);
        end
      end else begin
        send_job <= 1'b0;
        tail     <= status_result(st, cnt);
        if (word_valid) begin
          head <= word_res;
          rem  <= st_valid ? 4'd2 : 4'd1;
        end else begin
          head <= status_result(st, cnt);
          rem  <= st_valid ? 4'd1 : 4'd0;
        end
      end
    end else if (out_take) begin
      rem <= rem - 4'd1;
      if (send_job) begin
        tx_idx <= tx_idx + 3'd1;
        if (tx_idx < REQ_CRC_LO) begin
          tx_crc <= crc_byte(tx_crc, tx_cur);
        end
      end else begin
        head <= tail;
      end
    end
  end

endmodule

`default_nettype wire

@@ dv/mbrtu_read_checker.sv @@
// Checker for the Modbus RTU read-holding master: CRC helper package, response prediction and compare.
`timescale 1ns / 1ps

package mbrtu_tb_pkg;

  // Modbus CRC-16, reflected poly 0xA001, one byte at a time
  function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] acc;
    acc = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (acc[0]) acc = (acc >> 1) ^ 16'hA001;
      else acc = acc >> 1;
    end
    return acc;
  endfunction

endpackage

module mbrtu_read_checker
  import mbrtu_pkg::*, mbrtu_tb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  input  logic               s_tready,
  input  logic [InDataW-1:0] s_tdata,
  input  logic               s_tuser,
  input  logic               s_tlast,
  input  logic               m_tvalid,
  input  logic               m_tready,
  input  logic [OutDataW-1:0] m_tdata,
  input  logic [1:0]         m_tuser,
  input  logic               m_tlast,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [7:0]         cfg_data,
  output int                 mismatches,
  output int                 words_due
);

  result_t    due_words[$];

  logic [6:0]  qty_limit;
  logic [7:0]  word_room;
  logic [7:0]  peer_id;
  logic [7:0]  rx_pos;
  logic [7:0]  data_len;     // byte count field of the frame being parsed
  logic [7:0]  hi_byte;      // high half of a register pair, then CRC low byte
  logic [15:0] rx_crc;
  logic [2:0]  deferred_st;  // ST_OK means nothing deferred
  logic        frame_closed;

  function automatic void restart_rx();
    rx_pos       = 8'd0;
    data_len     = 8'd0;
    rx_crc       = 16'hFFFF;
    hi_byte      = 8'd0;
    deferred_st  = ST_OK;
    frame_closed = 1'b0;
  endfunction

  function automatic void expect_status(input logic [2:0] st, input logic [6:0] cnt);
    result_t r;
    r = '0;
    r.kind       = KIND_STATUS;
    r.status     = st;
    r.word_total = cnt;
    r.last       = 1'b1;
    due_words.push_back(r);
  endfunction

  function automatic void predict_request(input logic [7:0] sid, input logic [15:0] addr,
                                          input logic [15:0] qty);
    logic [7:0]  req [8];
    logic [15:0] crc;
    result_t     r;
    restart_rx();
    if (sid == 8'd0 || sid > MAX_SLAVE || qty == 16'd0 || qty > {9'd0, qty_limit} ||
        {1'b0, addr} + {1'b0, qty} > 17'h10000) begin
      expect_status(ST_REJECTED, 7'd0);
      return;
    end
    req[0] = sid;
    req[1] = FUNC_READ_HOLDING;
    req[2] = addr[15:8];
    req[3] = addr[7:0];
    req[4] = qty[15:8];
    req[5] = qty[7:0];
    crc = 16'hFFFF;
    for (int i = 0; i < 6; i++) crc = crc16_update(crc, req[i]);
    req[6] = crc[7:0];
    req[7] = crc[15:8];
    for (int i = 0; i < 8; i++) begin
      r = '0;
      r.kind    = KIND_TX;
      r.tx_byte = req[i];
      r.last    = (i == 7);
      due_words.push_back(r);
    end
    peer_id = sid;
  endfunction

  function automatic void predict_rx_byte(input logic [7:0] b, input logic lst);
    logic [7:0] off;
    logic       have_st;
    logic [2:0] st;
    logic [6:0] cnt;
    result_t    r;
    // after the verdict, bytes are dropped until the buffer ends
    if (frame_closed) begin
      if (lst) restart_rx();
      return;
    end
    have_st = 1'b0;
    st      = ST_OK;
    cnt     = 7'd0;
    if (rx_pos < HEADER_BYTES) begin
      rx_crc = crc16_update(rx_crc, b);
      if (rx_pos == 8'd0) begin
        if (b != peer_id) begin
          have_st = 1'b1;
          st      = ST_SLAVE;
        end
      end else if (rx_pos == 8'd1) begin
        if (b != FUNC_READ_HOLDING) begin
          have_st = 1'b1;
          st      = ST_FUNCTION;
        end
      end else if (b == 8'd0 || b[0] || b > MAX_BYTE_COUNT) begin
        have_st = 1'b1;
        st      = ST_COUNT;
      end else begin
        data_len = b;
        if (b[7:1] > word_room) deferred_st = ST_CAPACITY;
      end
    end else if (rx_pos < HEADER_BYTES + data_len) begin
      off    = rx_pos - HEADER_BYTES;
      rx_crc = crc16_update(rx_crc, b);
      if (!off[0]) begin
        hi_byte = b;
      end else if (deferred_st == ST_OK) begin
        r = '0;
        r.kind      = KIND_WORD;
        r.reg_value = {hi_byte, b};
        r.reg_index = off[7:1];
        due_words.push_back(r);
      end
    end else if (rx_pos == HEADER_BYTES + data_len) begin
      hi_byte = b;
    end else begin
      have_st = 1'b1;
      if (deferred_st != ST_OK) begin
        st = deferred_st;
      end else if ({b, hi_byte} == rx_crc) begin
        st  = ST_OK;
        cnt = data_len[7:1];
      end else begin
        st = ST_CRC;
      end
    end
    rx_pos = rx_pos + 8'd1;
    if (!have_st && lst) begin
      have_st = 1'b1;
      st      = ST_SHORT;
    end
    if (have_st) begin
      expect_status(st, cnt);
      frame_closed = 1'b1;
    end
    if (lst) restart_rx();
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void check_word();
    result_t e;
    if (due_words.size() == 0) begin
      $error("unexpected word: kind %0h data %0h", m_tuser, m_tdata);
      mismatches++;
      return;
    end
    e = due_words.pop_front();
    check_field("kind", {14'd0, e.kind}, {14'd0, m_tuser});
    check_field("tx_byte", {8'd0, e.tx_byte}, {8'd0, m_tdata[7:0]});
    check_field("reg_value", e.reg_value, m_tdata[23:8]);
    check_field("reg_index", {9'd0, e.reg_index}, {9'd0, m_tdata[30:24]});
    check_field("status", {13'd0, e.status}, {13'd0, m_tdata[33:31]});
    check_field("word_total", {9'd0, e.word_total}, {9'd0, m_tdata[40:34]});
    check_field("last", {15'd0, e.last}, {15'd0, m_tlast});
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      qty_limit  = 7'd125;
      word_room  = 8'd125;
      peer_id    = 8'd0;
      mismatches = 0;
      due_words.delete();
      restart_rx();
    end else begin
      // outputs first: a word leaving now never stems from an input taken now
      if (m_tvalid && m_tready) check_word();
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_MAX_QUANTITY) qty_limit = cfg_data[6:0];
        else word_room = cfg_data;
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser == CMD_SEND) predict_request(s_tdata[7:0], s_tdata[23:8], s_tdata[39:24]);
        else predict_rx_byte(s_tdata[47:40], s_tlast);
      end
    end
    words_due <= due_words.size();
  end

endmodule

@@ dv/tb.sv @@
// Testbench top: clock, reset, request/response stimulus and verdict for the Modbus RTU master.
`timescale 1ns / 1ps

module tb;
  import mbrtu_pkg::*, mbrtu_tb_pkg::*;

  // longest legal quiet stretch is the sink hold-off plus a source gap
  localparam int QUIET_LIMIT    = 2000;
  localparam int SQUEEZE_CYCLES = 300;
  localparam int PHASE_ITEMS    = 55;
  localparam int PHASE_FLOOR    = 16;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                s_tvalid  = 1'b0;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata   = '0;
  logic                s_tuser   = 1'b0;
  logic                s_tlast   = 1'b0;
  logic                m_tvalid;
  logic                m_tready  = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic [1:0]          m_tuser;
  logic                m_tlast;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [7:0]          cfg_data  = 8'd0;

  int          mismatches;
  int          words_due;
  int          items_sent = 0;
  int          quiet = 0;
  bit          src_gappy = 1'b0;
  int          squeeze_req = 0;   // bumped by the stimulus, followed by the sink
  logic [6:0]  qty_max = 7'd125;
  logic [7:0]  peer = 8'd0;
  logic [7:0]  frame_q[$];

  always #4 clk = ~clk;

  modbus_rtu_read_holding_master_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  mbrtu_read_checker u_chk (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .s_tlast    (s_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .words_due  (words_due)
  );

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet == QUIET_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // sink: short random stalls, calm stretches, and a long hold-off on request
  initial begin : sink
    int hold;
    int squeeze_seen;
    bit calm;
    hold = 0;
    squeeze_seen = 0;
    calm = 1'b0;
    forever begin
      @(posedge clk);
      if (squeeze_req != squeeze_seen) begin
        squeeze_seen = squeeze_req;
        m_tready    <= 1'b0;
        repeat (SQUEEZE_CYCLES) @(posedge clk);
      end
      if ($urandom_range(0, 63) == 0) calm = !calm;
      if (hold > 0) begin
        hold--;
        m_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        hold = ($urandom_range(0, 11) == 0) ? $urandom_range(12, 48) : $urandom_range(0, 2);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic put_word(input logic cmd, input logic [7:0] sid, input logic [15:0] addr,
                          input logic [15:0] qty, input logic [7:0] rxb, input logic lst);
    int gap;
    gap = 0;
    if ($urandom_range(0, 39) == 0) src_gappy = !src_gappy;
    if (src_gappy && $urandom_range(0, 2) == 0)
      gap = ($urandom_range(0, 11) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {rxb, qty, addr, sid};
    s_tlast  <= lst;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  // unused fields carry random junk
  task automatic send_req(input logic [7:0] sid, input logic [15:0] addr,
                          input logic [15:0] qty);
    put_word(CMD_SEND, sid, addr, qty, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  task automatic rx_byte(input logic [7:0] b, input logic lst);
    put_word(CMD_RX, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
             16'($urandom_range(0, 65535)), b, lst);
  endtask

  // well-formed response: header, random register data, valid CRC
  function automatic void build_frame(input logic [7:0] id, input int nwords);
    logic [7:0]  bc;
    logic [15:0] crc;
    bc = 8'(2 * nwords);
    frame_q = {};
    frame_q.push_back(id);
    frame_q.push_back(FUNC_READ_HOLDING);
    frame_q.push_back(bc);
    repeat (2 * nwords) frame_q.push_back(8'($urandom_range(0, 255)));
    crc = 16'hFFFF;
    foreach (frame_q[i]) crc = crc16_update(crc, frame_q[i]);
    frame_q.push_back(crc[7:0]);
    frame_q.push_back(crc[15:8]);
  endfunction

  task automatic drive_frame(input int upto, input bit close);
    for (int i = 0; i < upto; i++) rx_byte(frame_q[i], close && (i == upto - 1));
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (words_due != 0);
    // a byte with no word may still be in flight
    repeat (4) @(posedge clk);
  endtask

  task automatic load_config(input logic [7:0] mq, input logic [7:0] cap);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_MAX_QUANTITY;
    cfg_data  <= mq;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_REG_CAPACITY;
    cfg_data  <= cap;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    qty_max = mq[6:0];
  endtask

  task automatic directed_part();
    rx_byte(8'h00, 1'b1);               // no request yet: id 0 matches, cut short
    rx_byte(8'h05, 1'b1);               // id mismatch
    send_req(8'd0, 16'd0, 16'd1);
    send_req(8'd248, 16'd0, 16'd1);
    send_req(8'hFF, 16'hFFFF, 16'hFFFF);
    send_req(8'd1, 16'd0, 16'd0);
    send_req(8'd1, 16'd0, 16'd126);
    send_req(8'd1, 16'hFFFF, 16'd2);    // runs past the top of the address space
    send_req(8'd1, 16'hFFFF, 16'd1);
    send_req(MAX_SLAVE, 16'h0000, 16'd125);
    peer = MAX_SLAVE;
    build_frame(MAX_SLAVE, 1);
    drive_frame(frame_q.size(), 1'b0);
    rx_byte(8'hFF, 1'b1);               // trailing byte ends the buffer
    build_frame(MAX_SLAVE, 1);
    frame_q[1] = 8'h04;
    drive_frame(2, 1'b0);
    rx_byte(8'h00, 1'b1);
    build_frame(MAX_SLAVE, 1);
    frame_q[2] = 8'd3;                  // odd byte count
    drive_frame(3, 1'b1);
    build_frame(MAX_SLAVE, 1);
    drive_frame(4, 1'b0);
    send_req(8'd2, 16'h1234, 16'd1);    // new request mid-frame
    peer = 8'd2;
  endtask

  task automatic random_sequence();
    int         pick;
    int         nwords;
    int         k;
    logic [7:0] id;
    logic [7:0] mask;
    logic [15:0] qty;
    logic [15:0] addr;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      send_req(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
               16'($urandom_range(0, 65535)));
    end else if (pick < 20) begin
      repeat ($urandom_range(1, 4))
        rx_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
    end else begin
      if ($urandom_range(0, 19) != 0) begin
        if ($urandom_range(0, 9) == 0) id = $urandom_range(0, 1) ? 8'd1 : MAX_SLAVE;
        else id = 8'($urandom_range(1, 247));
        if (qty_max == 7'd0) qty = 16'($urandom_range(1, 3));
        else qty = 16'($urandom_range(1, qty_max));
        addr = 16'($urandom_range(0, 65536 - qty));
        send_req(id, addr, qty);
        if (qty_max != 7'd0) peer = id;
      end
      nwords = $urandom_range(1, 4);
      if ($urandom_range(0, 11) == 0) nwords = $urandom_range(5, 125);
      if ($urandom_range(0, 29) == 0) nwords = 125;
      build_frame(peer, nwords);
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        drive_frame(frame_q.size(), $urandom_range(0, 7) != 0);
      end else if (pick < 65) begin
        k = frame_q.size() - 1 - $urandom_range(0, 1);
        mask = 8'd1 << $urandom_range(0, 7);
        frame_q[k] = frame_q[k] ^ mask;
        drive_frame(frame_q.size(), 1'b1);
      end else if (pick < 73) begin
        drive_frame($urandom_range(1, frame_q.size() - 1), 1'b1);
      end else if (pick < 78) begin
        // abandoned: whatever comes next picks up the parse
        drive_frame($urandom_range(1, frame_q.size() - 1), 1'b0);
      end else if (pick < 83) begin
        id = 8'($urandom_range(1, 255));
        frame_q[0] = peer + id;
        drive_frame(frame_q.size(), 1'b1);
      end else if (pick < 88) begin
        id = 8'($urandom_range(1, 255));
        frame_q[1] = FUNC_READ_HOLDING + id;
        drive_frame(frame_q.size(), 1'b1);
      end else if (pick < 94) begin
        case ($urandom_range(0, 2))
          0:       frame_q[2] = 8'd0;
          1:       frame_q[2] = {7'($urandom_range(0, 127)), 1'b1};
          default: frame_q[2] = 8'($urandom_range(251, 255));
        endcase
        drive_frame(3 + $urandom_range(0, 2), 1'b1);
      end else begin
        drive_frame(frame_q.size(), 1'b0);
        repeat ($urandom_range(1, 3)) rx_byte(8'($urandom_range(0, 255)), 1'b0);
        rx_byte(8'($urandom_range(0, 255)), 1'b1);
      end
    end
  endtask

  initial begin : stimulus
    int phase_end;
    int run_base;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    directed_part();
    run_base = items_sent;
    for (int phase = 0; phase < 6; phase++) begin
      settle();
      case (phase)
        0:       load_config(8'd1, 8'd0);
        1:       load_config(8'd125, 8'd255);
        2:       load_config(8'd0, 8'd1);
        3:       load_config(8'hFF, 8'd2);
        4:       load_config(8'($urandom_range(1, 125)), 8'($urandom_range(0, 255)));
        default: load_config(8'd125, 8'd125);
      endcase
      // phases end on a fixed schedule so long frames do not pile up the count
      phase_end = run_base + (phase + 1) * PHASE_ITEMS;
      if (phase_end < items_sent + PHASE_FLOOR) phase_end = items_sent + PHASE_FLOOR;
      if (phase == 1 || phase == 4) squeeze_req++;
      random_sequence();
      while (items_sent < phase_end) random_sequence();
    end
    settle();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && words_due == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
